>>> sv/wlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlt_pkg: shared types and constants for whitespace and linefeed treatment
// Character codes, register indexes, count widths and the saturating adder.
// ----------------------------------------------------------------------------
package wlt_pkg;

  // Field widths of one input word and one result word.
  localparam int CHAR_W      = 16;
  localparam int SPACE_CNT_W = 12;

  // Space counts saturate here; internal counters are sized from it.
  localparam int MAX_SPACE_RUN = 4095;
  localparam int CNT_W         = $clog2(MAX_SPACE_RUN + 1);

  // Configuration port widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 2;

  // Character codes with special treatment.
  localparam logic [CHAR_W-1:0] CH_SPACE      = 16'h0020;
  localparam logic [CHAR_W-1:0] CH_LF         = 16'h000A;
  localparam logic [CHAR_W-1:0] CH_NBSP       = 16'h00A0;
  localparam logic [CHAR_W-1:0] CH_NBSP_SHOWN = 16'h00B0;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IGNORE_ALL_SPACE = 3'd0,
    CFG_IGNORE_BEFORE_LF = 3'd1,
    CFG_IGNORE_AFTER_LF  = 3'd2,
    CFG_LF_MODE          = 3'd3,
    CFG_COLLAPSE_SPACES  = 3'd4,
    CFG_SHOW_NBSP        = 3'd5
  } cfg_idx_e;

  // Linefeed handling; the unused code behaves like ignore.
  typedef enum logic [1:0] {
    LF_PRESERVE = 2'd0,
    LF_AS_SPACE = 2'd1,
    LF_IGNORE   = 2'd2
  } lf_mode_e;

  // Current register settings.
  typedef struct packed {
    logic       ignore_all_space;
    logic       ignore_before_lf;
    logic       ignore_after_lf;
    logic [1:0] lf_mode;
    logic       collapse_spaces;
    logic       show_nbsp;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic [SPACE_CNT_W-1:0] space_count;
    logic [CHAR_W-1:0]      out_char;
    logic                   char_valid;
    logic                   end_of_text;
  } res_t;

  // Saturating add of two space counts.
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > (CNT_W + 1)'(MAX_SPACE_RUN)) begin
      return CNT_W'(MAX_SPACE_RUN);
    end
    return s[CNT_W-1:0];
  endfunction

endpackage

>>> sv/wlt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlt_char_if / wlt_res_if: valid/ready channels
// One carries input characters, the other carries result words.
// ----------------------------------------------------------------------------
interface wlt_char_if;
  logic                      valid;
  logic                      ready;
  logic [wlt_pkg::CHAR_W-1:0] char_code;
  logic                      last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface wlt_res_if;
  logic                           valid;
  logic                           ready;
  logic [wlt_pkg::SPACE_CNT_W-1:0] space_count;
  logic [wlt_pkg::CHAR_W-1:0]      out_char;
  logic                           char_valid;
  logic                           end_of_text;

  modport source (output valid, output space_count, output out_char,
                  output char_valid, output end_of_text, input ready);
  modport sink   (input valid, input space_count, input out_char,
                  input char_valid, input end_of_text, output ready);
endinterface

>>> sv/whitespace_linefeed_treatment_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whitespace_linefeed_treatment_top: whitespace and linefeed treatment
// Strips, holds and releases space runs ahead of text characters.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word
//  char_i    in         char_code[15:0], last_char
//  res_o     out        space_count[11:0], out_char[15:0], char_valid, end_of_text
//  cfg_*     in         write enable, register index[2:0], data[1:0]
//
// One word is accepted every cycle while the result register is not stalled; a result
// passes through the input register, then the result register, set by the single step stage.
// Words that produce no result leave the input register without entering the result register.
// Reset clears the settings and all space state; no clearing pass is needed.
// A stalled result register holds its word and backs up into the input register.
module whitespace_linefeed_treatment_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  wlt_char_if.sink                       char_i,
  wlt_res_if.source                      res_o,
  input  logic                           cfg_we_i,
  input  logic [wlt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wlt_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  wlt_pkg::cfg_t cfg;
  wlt_pkg::res_t step_res;
  wlt_pkg::res_t out_res;
  logic          step_valid;
  logic          step_ready;

  wlt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  wlt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (char_i.valid),
    .in_ready_o  (char_i.ready),
    .in_char_i   (char_i.char_code),
    .in_last_i   (char_i.last_char),
    .res_valid_o (step_valid),
    .res_ready_i (step_ready),
    .res_o       (step_res)
  );

  wlt_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (step_valid),
    .push_ready_o (step_ready),
    .push_data_i  (step_res),
    .out_valid_o  (res_o.valid),
    .out_ready_i  (res_o.ready),
    .out_data_o   (out_res)
  );

  // Result word onto the output channel.
  assign res_o.space_count = out_res.space_count;
  assign res_o.out_char    = out_res.out_char;
  assign res_o.char_valid  = out_res.char_valid;
  assign res_o.end_of_text = out_res.end_of_text;

endmodule

>>> sv/wlt_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlt_cfg_regs: configuration register file
// Decodes the write port and holds the six treatment settings.
// ----------------------------------------------------------------------------
module wlt_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wlt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wlt_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output wlt_pkg::cfg_t                    cfg_o
);

  wlt_pkg::cfg_t cfg_d, cfg_q;

  // Write decode; unknown indexes leave the settings untouched.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        wlt_pkg::CFG_IGNORE_ALL_SPACE: cfg_d.ignore_all_space = cfg_wdata_i[0];
        wlt_pkg::CFG_IGNORE_BEFORE_LF: cfg_d.ignore_before_lf = cfg_wdata_i[0];
        wlt_pkg::CFG_IGNORE_AFTER_LF:  cfg_d.ignore_after_lf  = cfg_wdata_i[0];
        wlt_pkg::CFG_LF_MODE:          cfg_d.lf_mode          = cfg_wdata_i[1:0];
        wlt_pkg::CFG_COLLAPSE_SPACES:  cfg_d.collapse_spaces  = cfg_wdata_i[0];
        wlt_pkg::CFG_SHOW_NBSP:        cfg_d.show_nbsp        = cfg_wdata_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/wlt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlt_core: input register, text state and the per-character step logic
// Holds one character word, works out its result against the space state,
// and hands the result on when the output stage can take it.
// ----------------------------------------------------------------------------
module wlt_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wlt_pkg::cfg_t                  cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [wlt_pkg::CHAR_W-1:0]     in_char_i,
  input  logic                           in_last_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output wlt_pkg::res_t                  res_o
);

  localparam int CNT_W = wlt_pkg::CNT_W;

  // Input register.
  logic                       in_vld_q;
  logic [wlt_pkg::CHAR_W-1:0] char_q;
  logic                       last_q;

  // Text state.
  logic [CNT_W-1:0] held_q, held_d;
  logic [CNT_W-1:0] pend_q, pend_d;
  logic             plf_q, plf_d;
  logic             afl_q, afl_d;
  logic             pws_q, pws_d;
  logic             rign_q, rign_d;

  logic                       emit;
  logic                       advance;
  logic [CNT_W-1:0]           count;
  logic [wlt_pkg::CHAR_W-1:0] och;
  logic                       valid;
  logic [31:0]                count_wide;

  // Step logic for the registered character.
  always_comb begin
    held_d = held_q;
    pend_d = pend_q;
    plf_d  = plf_q;
    afl_d  = afl_q;
    pws_d  = pws_q;
    rign_d = rign_q;
    count  = '0;
    och    = '0;
    valid  = 1'b0;

    if (char_q == wlt_pkg::CH_SPACE) begin
      if (pws_q) begin
        if (!rign_q) begin
          pend_d = wlt_pkg::sat_add(pend_q, CNT_W'(1));
        end
      end else if (cfg_i.ignore_all_space || (afl_q && cfg_i.ignore_after_lf)) begin
        rign_d = 1'b1;
        afl_d  = 1'b0;
      end else begin
        rign_d = 1'b0;
        afl_d  = 1'b0;
        // A new run moves the pending run into the held count.
        if (pend_q != '0) begin
          held_d = wlt_pkg::sat_add(held_q, pend_q);
        end
        pend_d = CNT_W'(1);
        plf_d  = 1'b0;
      end
      pws_d = 1'b1;
    end else begin
      pws_d  = 1'b0;
      rign_d = 1'b0;
      if (char_q == wlt_pkg::CH_LF) begin
        afl_d = 1'b1;
        if (pend_q != '0 && !plf_q && cfg_i.ignore_before_lf) begin
          pend_d = '0;
        end
        case (cfg_i.lf_mode)
          wlt_pkg::LF_PRESERVE: begin
            if (pend_d != '0) begin
              count  = cfg_i.collapse_spaces ? CNT_W'(1)
                                             : wlt_pkg::sat_add(held_d, pend_d);
              held_d = '0;
              pend_d = '0;
              plf_d  = 1'b0;
            end
            och   = wlt_pkg::CH_LF;
            valid = 1'b1;
          end
          wlt_pkg::LF_AS_SPACE: begin
            if (pend_d != '0) begin
              held_d = wlt_pkg::sat_add(held_d, pend_d);
            end
            pend_d = CNT_W'(1);
            plf_d  = 1'b1;
          end
          default: begin
            // Ignored linefeed: nothing beyond the flags above.
          end
        endcase
      end else begin
        afl_d = 1'b0;
        if (pend_q != '0) begin
          count  = cfg_i.collapse_spaces ? CNT_W'(1)
                                         : wlt_pkg::sat_add(held_q, pend_q);
          held_d = '0;
          pend_d = '0;
          plf_d  = 1'b0;
        end
        och   = (char_q == wlt_pkg::CH_NBSP && cfg_i.show_nbsp) ?
                wlt_pkg::CH_NBSP_SHOWN : char_q;
        valid = 1'b1;
      end
    end

    // End of text without a character still releases a pending run.
    if (last_q && !valid && pend_d != '0) begin
      count = cfg_i.collapse_spaces ? CNT_W'(1) : wlt_pkg::sat_add(held_d, pend_d);
    end

    // The text closes: all state returns to its reset values.
    if (last_q) begin
      held_d = '0;
      pend_d = '0;
      plf_d  = 1'b0;
      afl_d  = 1'b0;
      pws_d  = 1'b0;
      rign_d = 1'b0;
    end
  end

  assign emit       = valid || last_q;
  assign advance    = in_vld_q && (!emit || res_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  assign count_wide        = 32'(count);
  assign res_valid_o       = in_vld_q && emit;
  assign res_o.space_count = count_wide[wlt_pkg::SPACE_CNT_W-1:0];
  assign res_o.out_char    = och;
  assign res_o.char_valid  = valid;
  assign res_o.end_of_text = last_q;

  // Input word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= in_char_i;
      last_q <= in_last_i;
    end
  end

  // Text state moves on when the registered word is consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pend_q <= '0;
      plf_q  <= 1'b0;
      afl_q  <= 1'b0;
      pws_q  <= 1'b0;
      rign_q <= 1'b0;
    end else if (advance) begin
      held_q <= held_d;
      pend_q <= pend_d;
      plf_q  <= plf_d;
      afl_q  <= afl_d;
      pws_q  <= pws_d;
      rign_q <= rign_d;
    end
  end

endmodule

>>> sv/wlt_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlt_out_reg: result register
// Holds one result word until the sink takes it; refills in the same cycle.
// ----------------------------------------------------------------------------
module wlt_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  wlt_pkg::res_t   push_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output wlt_pkg::res_t   out_data_o
);

  logic          vld_q;
  wlt_pkg::res_t data_q;

  assign push_ready_o = !vld_q || out_ready_i;
  assign out_valid_o  = vld_q;
  assign out_data_o   = data_q;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (push_ready_o) begin
      vld_q <= push_valid_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (push_ready_o && push_valid_i) begin
      data_q <= push_data_i;
    end
  end

endmodule

>>> sv/wlt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlt_checker: port-level checks for whitespace and linefeed treatment
// Watches the result channel over time and flags malformed result words.
// ----------------------------------------------------------------------------
module wlt_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [wlt_pkg::SPACE_CNT_W-1:0]   space_count_i,
  input logic [wlt_pkg::CHAR_W-1:0]        out_char_i,
  input logic                              char_valid_i,
  input logic                              end_of_text_i
);

  // A stalled result word stays put.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(space_count_i) &&
      $stable(out_char_i) && $stable(char_valid_i) && $stable(end_of_text_i))
    else $error("result word changed while stalled");

  // A word without a character only ever closes a text.
  a_quiet_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !char_valid_i |-> end_of_text_i)
    else $error("result word without character or end of text");

  // No character means a zero character field.
  a_empty_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !char_valid_i |-> out_char_i == '0)
    else $error("empty result carries a character code");

  // Spaces are never passed through as characters; they are counted or dropped.
  a_no_space_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && char_valid_i |-> out_char_i != wlt_pkg::CH_SPACE)
    else $error("space passed through as a character");

endmodule

bind whitespace_linefeed_treatment_top wlt_checker u_wlt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .space_count_i (res_o.space_count),
  .out_char_i    (res_o.out_char),
  .char_valid_i  (res_o.char_valid),
  .end_of_text_i (res_o.end_of_text)
);
